### rtl/sle_pkg.sv
// Shared constants, types and codes for the sequential list engine.
package sle_pkg;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 64;
  localparam int KEY_W      = 32;
  localparam int POS_W      = 10;
  localparam int OP_W       = 3;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ENTRY_W    = KEY_W + VALUE_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMKEY = 3'd2,
    OP_REMAT  = 3'd3,
    OP_UPDATE = 3'd4,
    OP_GETKEY = 3'd5,
    OP_GETNTH = 3'd6
  } sle_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHDN,
    ST_SHUP,
    ST_INSWR,
    ST_GETW
  } sle_state_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } sle_mreq_t;

  typedef struct packed {
    logic                  ok;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      count;
  } sle_res_t;

endpackage

### rtl/sle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sle_ctrl.sv
// Sequencer that walks the entry memory for search, shift and access.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [KEY_W-1:0]      in_entry_key,
  input  logic [63:0]           in_entry_value,
  input  logic [POS_W-1:0]      in_position,
  output logic                  busy,
  output sle_mreq_t             mreq,
  input  logic [ENTRY_W-1:0]    rd_data,
  output logic                  res_vld,
  output sle_res_t              res
);

  sle_state_t            state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      addr_r, addr_nxt;
  logic [CNT_W-1:0]      paddr_r, paddr_nxt;
  logic                  pv_r, pv_nxt;
  logic                  more_r, more_nxt;

  logic [CNT_W-1:0]      cnt_m1;
  logic [IDX_W-1:0]      pos_x;
  logic [IDX_W-1:0]      cnt_x;
  logic [KEY_W-1:0]      rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign pos_x  = IDX_W'(pos_r);
  assign cnt_x  = IDX_W'(cnt_r);
  assign rd_key = rd_data[ENTRY_W-1 -: KEY_W];
  assign rd_val = rd_data[VALUE_BITS-1:0];
  assign busy   = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      more_r  <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    pos_r   <= pos_nxt;
    addr_r  <= addr_nxt;
    paddr_r <= paddr_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    paddr_nxt = paddr_r;
    pv_nxt    = 1'b0;
    more_nxt  = more_r;
    mreq      = '0;
    res_vld   = 1'b0;
    res       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          key_nxt   = in_entry_key;
          val_nxt   = in_entry_value[VALUE_BITS-1:0];
          pos_nxt   = in_position;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_vld   = 1'b1;
        state_nxt = ST_IDLE;
        case (op_r)
          OP_APPEND: begin
            if (cnt_r < CNT_W'(CAPACITY)) begin
              mreq.we    = 1'b1;
              mreq.waddr = ADDR_W'(cnt_r);
              mreq.wdata = {key_r, val_r};
              cnt_nxt    = cnt_r + CNT_W'(1);
              res.ok     = 1'b1;
            end
          end
          OP_INSERT: begin
            if (cnt_r < CNT_W'(CAPACITY) && pos_x <= cnt_x) begin
              if (pos_x == cnt_x) begin
                mreq.we    = 1'b1;
                mreq.waddr = ADDR_W'(pos_r);
                mreq.wdata = {key_r, val_r};
                cnt_nxt    = cnt_r + CNT_W'(1);
                res.ok     = 1'b1;
              end else begin
                res_vld    = 1'b0;
                mreq.re    = 1'b1;
                mreq.raddr = ADDR_W'(cnt_m1);
                pv_nxt     = 1'b1;
                paddr_nxt  = cnt_m1;
                addr_nxt   = cnt_m1 - CNT_W'(1);
                more_nxt   = (IDX_W'(cnt_m1) != pos_x);
                state_nxt  = ST_SHUP;
              end
            end
          end
          OP_REMKEY, OP_UPDATE, OP_GETKEY: begin
            if (cnt_r != '0) begin
              res_vld    = 1'b0;
              mreq.re    = 1'b1;
              mreq.raddr = '0;
              pv_nxt     = 1'b1;
              paddr_nxt  = '0;
              addr_nxt   = CNT_W'(1);
              more_nxt   = (cnt_m1 != '0);
              state_nxt  = ST_SCAN;
            end
          end
          OP_REMAT: begin
            if (pos_x < cnt_x) begin
              if (pos_x == IDX_W'(cnt_m1)) begin
                cnt_nxt = cnt_m1;
                res.ok  = 1'b1;
              end else begin
                res_vld    = 1'b0;
                mreq.re    = 1'b1;
                mreq.raddr = ADDR_W'(pos_r) + ADDR_W'(1);
                pv_nxt     = 1'b1;
                paddr_nxt  = CNT_W'(pos_r) + CNT_W'(1);
                addr_nxt   = CNT_W'(pos_r) + CNT_W'(2);
                more_nxt   = (pos_x + IDX_W'(1) != IDX_W'(cnt_m1));
                state_nxt  = ST_SHDN;
              end
            end
          end
          OP_GETNTH: begin
            if (pos_x < cnt_x) begin
              res_vld    = 1'b0;
              mreq.re    = 1'b1;
              mreq.raddr = ADDR_W'(pos_r);
              state_nxt  = ST_GETW;
            end
          end
          default: begin
          end
        endcase
        res.count = cnt_nxt;
      end

      ST_SCAN: begin
        mreq.re    = more_r;
        mreq.raddr = ADDR_W'(addr_r);
        pv_nxt     = more_r;
        paddr_nxt  = addr_r;
        addr_nxt   = addr_r + CNT_W'(1);
        more_nxt   = more_r && (addr_r != cnt_m1);
        if (pv_r) begin
          if (rd_key == key_r) begin
            case (op_r)
              OP_GETKEY: begin
                res_vld   = 1'b1;
                res.ok    = 1'b1;
                res.key   = rd_key;
                res.value = rd_val;
                state_nxt = ST_IDLE;
              end
              OP_UPDATE: begin
                mreq.we    = 1'b1;
                mreq.waddr = ADDR_W'(paddr_r);
                mreq.wdata = {rd_key, val_r};
                res_vld    = 1'b1;
                res.ok     = 1'b1;
                state_nxt  = ST_IDLE;
              end
              default: begin
                if (paddr_r == cnt_m1) begin
                  cnt_nxt   = cnt_m1;
                  res_vld   = 1'b1;
                  res.ok    = 1'b1;
                  state_nxt = ST_IDLE;
                end else begin
                  mreq.re    = 1'b1;
                  mreq.raddr = ADDR_W'(paddr_r) + ADDR_W'(1);
                  pv_nxt     = 1'b1;
                  paddr_nxt  = paddr_r + CNT_W'(1);
                  addr_nxt   = paddr_r + CNT_W'(2);
                  more_nxt   = (paddr_r + CNT_W'(1) != cnt_m1);
                  state_nxt  = ST_SHDN;
                end
              end
            endcase
          end else if (paddr_r == cnt_m1) begin
            res_vld   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
        res.count = cnt_nxt;
      end

      ST_SHDN: begin
        mreq.re    = more_r;
        mreq.raddr = ADDR_W'(addr_r);
        pv_nxt     = more_r;
        paddr_nxt  = addr_r;
        addr_nxt   = addr_r + CNT_W'(1);
        more_nxt   = more_r && (addr_r != cnt_m1);
        if (pv_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = ADDR_W'(paddr_r) - ADDR_W'(1);
          mreq.wdata = rd_data;
          if (paddr_r == cnt_m1) begin
            cnt_nxt   = cnt_m1;
            res_vld   = 1'b1;
            res.ok    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
        res.count = cnt_nxt;
      end

      ST_SHUP: begin
        mreq.re    = more_r;
        mreq.raddr = ADDR_W'(addr_r);
        pv_nxt     = more_r;
        paddr_nxt  = addr_r;
        addr_nxt   = addr_r - CNT_W'(1);
        more_nxt   = more_r && (IDX_W'(addr_r) != pos_x);
        if (pv_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = ADDR_W'(paddr_r) + ADDR_W'(1);
          mreq.wdata = rd_data;
          if (IDX_W'(paddr_r) == pos_x) begin
            state_nxt = ST_INSWR;
          end
        end
        res.count = cnt_nxt;
      end

      ST_INSWR: begin
        mreq.we    = 1'b1;
        mreq.waddr = ADDR_W'(pos_r);
        mreq.wdata = {key_r, val_r};
        cnt_nxt    = cnt_r + CNT_W'(1);
        res_vld    = 1'b1;
        res.ok     = 1'b1;
        res.count  = cnt_nxt;
        state_nxt  = ST_IDLE;
      end

      ST_GETW: begin
        res_vld   = 1'b1;
        res.ok    = 1'b1;
        res.key   = rd_key;
        res.value = rd_val;
        res.count = cnt_r;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/sequential_list_engine_core.sv
// Top level of the sequential list engine: sequencer, entry memory, result register.
// From accept, each word passes through the execute state and, where needed, the scan, shift or
// read-wait states, which read the entries in order (a key search stops at the hit), before its
// result is registered onto out_strobe; insert and remove move each entry behind the position.
// One word at a time: busy stays high until the result is registered.
// Reset clears the count and control only; the entry memory needs no clearing pass.
module sequential_list_engine_core
  import sle_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic signed [31:0] in_entry_key,
  input  logic [63:0]        in_entry_value,
  input  logic [POS_W-1:0]   in_position,
  output logic               out_strobe,
  output logic               out_success,
  output logic signed [31:0] out_found_key,
  output logic [63:0]        out_found_value,
  output logic [10:0]        out_entry_count,
  output logic               out_list_full,
  output logic               out_list_empty
);

  sle_mreq_t          mreq;
  logic [ENTRY_W-1:0] rd_data;
  logic               res_vld;
  sle_res_t           res;

  logic               out_strobe_r;
  logic               out_success_r;
  logic [31:0]        out_found_key_r;
  logic [63:0]        out_found_value_r;
  logic [10:0]        out_entry_count_r;
  logic               out_list_full_r;
  logic               out_list_empty_r;

  sle_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_opcode      (in_opcode),
    .in_entry_key   (in_entry_key),
    .in_entry_value (in_entry_value),
    .in_position    (in_position),
    .busy           (busy),
    .mreq           (mreq),
    .rd_data        (rd_data),
    .res_vld        (res_vld),
    .res            (res)
  );

  sle_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .re    (mreq.re),
    .raddr (mreq.raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_success_r     <= res.ok;
      out_found_key_r   <= res.key;
      out_found_value_r <= 64'(res.value);
      out_entry_count_r <= 11'(res.count);
      out_list_full_r   <= (res.count == CNT_W'(CAPACITY));
      out_list_empty_r  <= (res.count == '0);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_success     = out_success_r;
  assign out_found_key   = out_found_key_r;
  assign out_found_value = out_found_value_r;
  assign out_entry_count = out_entry_count_r;
  assign out_list_full   = out_list_full_r;
  assign out_list_empty  = out_list_empty_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_success) |-> (out_found_key == 0 && out_found_value == 64'd0))
    else $error("refused word returned entry data");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_entry_count <= 11'(CAPACITY) && !(out_list_full && out_list_empty)))
    else $error("count or flags out of range");

endmodule

### sim/tb_sequential_list_engine_core.sv
// Testbench for the sequential list engine core: directed and random list operations checked against a queue model.
`timescale 1ns / 1ps

module tb_sequential_list_engine_core;
  import sle_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED  = 3'd7;
  localparam logic [63:0]     VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam int              DRAIN_LIMIT = 4 * CAPACITY + 100;

  typedef struct packed {
    logic               success;
    logic signed [31:0] key;
    logic [63:0]        value;
    logic [10:0]        count;
    logic               full;
    logic               empty;
  } list_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    in_opcode;
  logic signed [31:0] in_entry_key;
  logic [63:0]        in_entry_value;
  logic [POS_W-1:0]   in_position;
  logic               out_strobe;
  logic               out_success;
  logic signed [31:0] out_found_key;
  logic [63:0]        out_found_value;
  logic [10:0]        out_entry_count;
  logic               out_list_full;
  logic               out_list_empty;

  logic signed [31:0] key_list[$];
  logic [63:0]        value_list[$];
  list_result_t       pending_results[$];
  list_result_t       want;
  int                 error_count = 0;
  int                 burst_left = 0;

  sequential_list_engine_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_entry_key    (in_entry_key),
    .in_entry_value  (in_entry_value),
    .in_position     (in_position),
    .out_strobe      (out_strobe),
    .out_success     (out_success),
    .out_found_key   (out_found_key),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count),
    .out_list_full   (out_list_full),
    .out_list_empty  (out_list_empty)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (error_count < 100) begin
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    end
    error_count++;
  endtask

  function automatic int key_index(logic signed [31:0] key);
    int idx;
    idx = key_list.size();
    for (int i = 0; i < key_list.size(); i++) begin
      if (key_list[i] == key) begin
        idx = i;
        break;
      end
    end
    return idx;
  endfunction

  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic signed [31:0] key,
                                                 logic [63:0] val, int pos);
    list_result_t r;
    int           cnt;
    int           hit;
    r   = '0;
    cnt = key_list.size();
    val = val & VALUE_MASK;
    hit = key_index(key);
    case (op)
      OP_APPEND: begin
        if (cnt < CAPACITY) begin
          key_list.push_back(key);
          value_list.push_back(val);
          r.success = 1'b1;
        end
      end
      OP_INSERT: begin
        if (cnt < CAPACITY && pos <= cnt) begin
          key_list.insert(pos, key);
          value_list.insert(pos, val);
          r.success = 1'b1;
        end
      end
      OP_REMKEY: begin
        if (hit < cnt) begin
          key_list.delete(hit);
          value_list.delete(hit);
          r.success = 1'b1;
        end
      end
      OP_REMAT: begin
        if (pos < cnt) begin
          key_list.delete(pos);
          value_list.delete(pos);
          r.success = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (hit < cnt) begin
          value_list[hit] = val;
          r.success = 1'b1;
        end
      end
      OP_GETKEY: begin
        if (hit < cnt) begin
          r.key     = key_list[hit];
          r.value   = value_list[hit];
          r.success = 1'b1;
        end
      end
      OP_GETNTH: begin
        if (pos < cnt) begin
          r.key     = key_list[pos];
          r.value   = value_list[pos];
          r.success = 1'b1;
        end
      end
      default: begin
      end
    endcase
    cnt     = key_list.size();
    r.count = cnt[10:0];
    r.full  = (cnt == CAPACITY);
    r.empty = (cnt == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_entry_count), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_success !== want.success)
          report_mismatch("success", 64'(out_success), 64'(want.success));
        if (out_found_key !== want.key)
          report_mismatch("found_key", 64'(unsigned'(out_found_key)), 64'(unsigned'(want.key)));
        if (out_found_value !== want.value)
          report_mismatch("found_value", out_found_value, want.value);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", 64'(out_entry_count), 64'(want.count));
        if (out_list_full !== want.full)
          report_mismatch("list_full", 64'(out_list_full), 64'(want.full));
        if (out_list_empty !== want.empty)
          report_mismatch("list_empty", 64'(out_list_empty), 64'(want.empty));
      end
    end
  end

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 40);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [31:0] key,
                           input logic [63:0] val, input logic [POS_W-1:0] pos);
    @(negedge clk);
    start          <= 1'b1;
    in_opcode      <= op;
    in_entry_key   <= key;
    in_entry_value <= val;
    in_position    <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_list_op(op, key, val, int'(pos)));
    pace_sender();
  endtask

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (key_list.size() > 0 && r < 6) return key_list[$urandom_range(0, key_list.size() - 1)];
    if (r < 8) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic logic [63:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    int cnt;
    r   = $urandom_range(0, 9);
    cnt = key_list.size();
    if (r < 7) return POS_W'($urandom_range(0, cnt));
    if (r < 9) return POS_W'(cnt);
    return POS_W'($urandom_range(0, 1023));
  endfunction

  task automatic test_empty_list();
    send_word(OP_REMAT,  32'sd0, 64'd0, 10'd0);
    send_word(OP_GETNTH, 32'sd0, 64'd0, 10'd0);
    send_word(OP_REMKEY, 32'sd0, 64'd0, 10'd0);
    send_word(OP_GETKEY, 32'sd0, 64'd0, 10'd0);
    send_word(OP_UPDATE, 32'sd0, '1,    10'd0);
    send_word(OP_INSERT, 32'sd5, '1,    10'd1);
    send_word(OP_INSERT, 32'sd5, '1,    10'd1023);
    send_word(OP_UNUSED, '1,     '1,    '1);
  endtask

  task automatic test_basic_ops();
    send_word(OP_APPEND, 32'sh8000_0000, '1,    10'd0);
    send_word(OP_APPEND, 32'sh7fff_ffff, 64'd0, 10'd0);
    send_word(OP_INSERT, -32'sd1, 64'h0123_4567_89ab_cdef, 10'd0);
    send_word(OP_INSERT, 32'sh8000_0000, 64'hdead_beef_0000_0001, 10'd1);
    send_word(OP_INSERT, 32'sd0, 64'h8000_0000_0000_0000, 10'd4);
    send_word(OP_GETKEY, 32'sh8000_0000, 64'd0, 10'd0);
    send_word(OP_UPDATE, 32'sh8000_0000, 64'h5555_aaaa_5555_aaaa, 10'd0);
    send_word(OP_GETNTH, 32'sd0, 64'd0, 10'd1);
    send_word(OP_GETNTH, 32'sd0, 64'd0, 10'd2);
    send_word(OP_REMKEY, 32'sh8000_0000, 64'd0, 10'd0);
    send_word(OP_GETNTH, 32'sd0, 64'd0, 10'd4);
    send_word(OP_REMAT,  32'sd0, 64'd0, 10'd1);
    send_word(OP_GETKEY, 32'sd12345, 64'd0, 10'd0);
    send_word(OP_REMAT,  32'sd0, 64'd0, 10'd2);
    send_word(OP_GETNTH, 32'sd0, 64'd0, 10'd0);
    send_word(OP_UNUSED, 32'sd0, 64'd0, 10'd0);
  endtask

  task automatic test_random_mix(input int n);
    int               goal;
    int               r;
    logic             grow;
    logic [OP_W-1:0]  op;
    goal = 8;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        goal = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) : $urandom_range(0, 40);
      end
      grow = (key_list.size() < goal);
      r    = $urandom_range(0, 99);
      if (r < 2) op = OP_UNUSED;
      else if (r < (grow ? 40 : 15)) op = OP_APPEND;
      else if (r < (grow ? 60 : 25)) op = OP_INSERT;
      else if (r < (grow ? 67 : 45)) op = OP_REMKEY;
      else if (r < (grow ? 74 : 65)) op = OP_REMAT;
      else if (r < 82) op = OP_UPDATE;
      else if (r < 91) op = OP_GETKEY;
      else op = OP_GETNTH;
      send_word(op, pick_key(), pick_value(), pick_position());
    end
  endtask

  task automatic test_full_list();
    logic signed [31:0] absent_key;
    while (key_list.size() < CAPACITY) begin
      send_word(OP_APPEND, pick_key(), pick_value(), POS_W'($urandom));
    end
    do absent_key = $urandom; while (key_index(absent_key) < key_list.size());
    send_word(OP_APPEND, 32'sd1, '1, 10'd0);
    send_word(OP_INSERT, 32'sd1, '1, 10'd0);
    send_word(OP_INSERT, 32'sd1, '1, 10'd1023);
    send_word(OP_GETNTH, 32'sd0, 64'd0, 10'd1023);
    send_word(OP_GETKEY, absent_key, 64'd0, 10'd0);
    send_word(OP_UPDATE, key_list[CAPACITY-1], pick_value(), 10'd0);
    send_word(OP_GETKEY, key_list[CAPACITY-1], 64'd0, 10'd0);
    send_word(OP_REMAT,  32'sd0, 64'd0, 10'd0);
    send_word(OP_INSERT, absent_key, pick_value(), 10'd0);
    send_word(OP_REMKEY, absent_key, 64'd0, 10'd0);
    send_word(OP_REMAT,  32'sd0, 64'd0, 10'd1023);
    send_word(OP_REMAT,  32'sd0, 64'd0, 10'd1022);
    send_word(OP_GETNTH, 32'sd0, 64'd0, 10'd1022);
  endtask

  initial begin
    int waited;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_opcode      = OP_APPEND;
    in_entry_key   = '0;
    in_entry_value = '0;
    in_position    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_basic_ops();
    test_random_mix(580);
    test_full_list();

    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    while (pending_results.size() != 0) begin
      want = pending_results.pop_front();
      report_mismatch("result never arrived", 64'(want.count), 64'(want.success));
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
